// ----- rtl/mrcid_pkg.sv -----
// Shared types and helper functions for the Manchester rotation canonical ID unit.
package mrcid_pkg;

   localparam int CodeBits = 64;
   localparam int IdBits   = 32;
   localparam int CfgBits  = 6;
   localparam int CntBits  = 7;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_CHECK,
      ST_DONE
   } state_type;

   // Manchester encode: pair k = 10 for a one, 01 for a zero; pairs at or above n are zero
   function automatic logic [CodeBits-1:0] mc_encode(logic [IdBits-1:0] id,
                                                     logic [CfgBits-1:0] n);
      logic [CodeBits-1:0] code;
      code = '0;
      for (int k = 0; k < IdBits; k++) begin
         if (CfgBits'(k) < n) begin
            code[2*k]   = ~id[k];
            code[2*k+1] = id[k];
         end
      end
      return code;
   endfunction

   // True when the low n pairs are all 01 or 10
   function automatic logic mc_pairs_ok(logic [CodeBits-1:0] code, logic [CfgBits-1:0] n);
      logic ok;
      ok = 1'b1;
      for (int k = 0; k < IdBits; k++) begin
         if (CfgBits'(k) < n && !(code[2*k] ^ code[2*k+1])) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

   // Decode: ID bit k is the high bit of pair k
   function automatic logic [IdBits-1:0] mc_decode(logic [CodeBits-1:0] code);
      logic [IdBits-1:0] id;
      for (int k = 0; k < IdBits; k++) begin
         id[k] = code[2*k+1];
      end
      return id;
   endfunction

endpackage

// ----- rtl/manchester_rotation_canonical_id_unit.sv -----
// Top level of the Manchester rotation canonical ID unit: sequencer around one rotate/compare unit.
// Each item runs a search pass of 2n rotations (n = effective id_bits), then a symmetry pass
//   of 2n-1 rotations of the minimum, then a hand-off state that waits for the output register.
// Throughput: one item at a time, set by the single shared 64-bit rotate/compare unit; the
//   next transfer is taken only in the idle state, after the hand-off of the last result.
// A finished result sits in the output register while the next item is taken.
// Reset (synchronous, active high): id_bits returns to 8, sequencer idles, no result valid.
module manchester_rotation_canonical_id_unit #(
   parameter int MAX_ID_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [5:0]  csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_raw_id,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_encoded_code,
   output logic [63:0] rsp_minimal_code,
   output logic [31:0] rsp_canonical_id,
   output logic        rsp_asymmetric
);
   import mrcid_pkg::*;

   localparam logic [CfgBits-1:0] IdBitsReset = CfgBits'(8);
   localparam logic [CfgBits-1:0] MaxN        = CfgBits'(MAX_ID_BITS);

   // configuration register
   logic [CfgBits-1:0]  id_bits_ff;

   // sequencer and working registers
   state_type           state_ff, state_in;
   logic [CntBits-1:0]  cnt_ff, cnt_in;
   logic [CfgBits-1:0]  n_ff, n_in;
   logic [CodeBits-1:0] top_ff, top_in;     // one-hot: bit 2n-1 of the window
   logic [CodeBits-1:0] code_ff, code_in;
   logic [CodeBits-1:0] rot_ff, rot_in;
   logic [CodeBits-1:0] best_ff, best_in;
   logic                asym_ff, asym_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CodeBits-1:0] rsp_code_ff, rsp_code_in;
   logic [CodeBits-1:0] rsp_min_ff, rsp_min_in;
   logic [IdBits-1:0]   rsp_id_ff, rsp_id_in;
   logic                rsp_asym_ff, rsp_asym_in;

   // shared unit: one-bit right rotation inside the 2n-bit window
   logic [CodeBits-1:0] rot_next;
   logic [CodeBits-1:0] window_mask;
   logic [CfgBits-1:0]  n_eff;

   assign rot_next    = {1'b0, rot_ff[CodeBits-1:1]} | (rot_ff[0] ? top_ff : '0);
   assign window_mask = (top_ff << 1) - CodeBits'(1);   // wraps to all ones at n = 32

   // id_bits zero acts as 1, above the maximum saturates
   assign n_eff = (id_bits_ff == '0) ? CfgBits'(1) :
                  (id_bits_ff > MaxN) ? MaxN : id_bits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         id_bits_ff <= IdBitsReset;
      end else if (csr_wr_en) begin
         id_bits_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      top_ff      <= top_in;
      code_ff     <= code_in;
      rot_ff      <= rot_in;
      best_ff     <= best_in;
      asym_ff     <= asym_in;
      rsp_code_ff <= rsp_code_in;
      rsp_min_ff  <= rsp_min_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_asym_ff <= rsp_asym_in;
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      top_in       = top_ff;
      code_in      = code_ff;
      rot_in       = rot_ff;
      best_in      = best_ff;
      asym_in      = asym_ff;
      rsp_code_in  = rsp_code_ff;
      rsp_min_in   = rsp_min_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_asym_in  = rsp_asym_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               // latch n, build the code, start 2n search rotations
               n_in     = n_eff;
               top_in   = CodeBits'(1) << ({n_eff, 1'b0} - 7'd1);
               code_in  = mc_encode(req_raw_id, n_eff);
               rot_in   = mc_encode(req_raw_id, n_eff);
               best_in  = mc_encode(req_raw_id, n_eff);
               cnt_in   = {n_eff, 1'b0};
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            rot_in = rot_next;
            if (rot_next < best_ff && mc_pairs_ok(rot_next, n_ff)) begin
               best_in = rot_next;
            end
            cnt_in = cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) begin
               // symmetry pass: rotate the minimum by 1 .. 2n-1
               rot_in   = (rot_next < best_ff && mc_pairs_ok(rot_next, n_ff)) ?
                          rot_next : best_ff;
               asym_in  = 1'b1;
               cnt_in   = {n_ff, 1'b0} - 7'd1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            rot_in = rot_next;
            if (rot_next == best_ff) begin
               asym_in = 1'b0;
            end
            cnt_in = cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hand off once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = code_ff;
               rsp_min_in   = best_ff;
               rsp_id_in    = mc_decode(best_ff);
               rsp_asym_in  = asym_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_encoded_code = rsp_code_ff;
   assign rsp_minimal_code = rsp_min_ff;
   assign rsp_canonical_id = rsp_id_ff;
   assign rsp_asymmetric   = rsp_asym_ff;

   // the running minimum never exceeds the unrotated code
   a_best_le_code: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH || state_ff == ST_CHECK) |-> best_ff <= code_ff)
      else $error("minimum above encoded code");

   // the minimum handed off is always a valid Manchester code
   a_best_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> mc_pairs_ok(best_ff, n_ff))
      else $error("minimum has an invalid pair");

   // rotations stay inside the 2n-bit window
   a_rot_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH || state_ff == ST_CHECK) |-> (rot_ff & ~window_mask) == '0)
      else $error("rotation escaped the window");

   // iteration count never exceeds the widest window
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH || state_ff == ST_CHECK) |-> (cnt_ff != '0 && cnt_ff <= 7'd64))
      else $error("iteration count out of range");

   // a waiting result is never overwritten by the sequencer
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_minimal_code) && rsp_valid)
      else $error("pending result changed");

endmodule

// ----- tb/sv/manchester_rotation_canonical_id_unit_tb.sv -----
// Self-checking testbench for the Manchester rotation canonical ID unit.
module manchester_rotation_canonical_id_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mrcid_pkg::*;

   localparam int unsigned MAX_ID     = 32;
   localparam int unsigned ID_RESET   = 8;
   // Worst case result wait at n = 32, with slack on top.
   localparam int unsigned SETTLE     = 4 * MAX_ID + 9;
   // Longest quiet stretch of a correct run: sender gap + one item's work
   // + receiver stall + settle pause; the limit covers it several times over.
   localparam int unsigned IDLE_LIMIT = 5000;

   // One result transfer, as predicted.
   typedef struct packed {
      logic [CodeBits-1:0] encoded;
      logic [CodeBits-1:0] minimal;
      logic [IdBits-1:0]   canon;
      logic                asym;
   } id_result_type;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                csr_wr_en   = 1'b0;
   logic [CfgBits-1:0]  csr_wr_data = '0;
   logic                req_valid   = 1'b0;
   logic                req_ready;
   logic [IdBits-1:0]   req_raw_id  = '0;
   logic                rsp_valid;
   logic                rsp_ready   = 1'b0;
   logic [CodeBits-1:0] rsp_encoded_code;
   logic [CodeBits-1:0] rsp_minimal_code;
   logic [IdBits-1:0]   rsp_canonical_id;
   logic                rsp_asymmetric;

   // Predictor copy of the id_bits register (reset value 8).
   logic [CfgBits-1:0]  id_bits_shadow = CfgBits'(ID_RESET);
   id_result_type       canon_expect_q[$];

   int unsigned items_sent      = 0;
   int unsigned results_checked = 0;
   int unsigned mismatch_count  = 0;
   int unsigned width_writes    = 0;
   int unsigned idle_cycles     = 0;
   int unsigned ready_hold      = 0;
   bit          send_idle_en    = 1'b1;
   bit          rsp_idle_en     = 1'b1;

   manchester_rotation_canonical_id_unit #(
      .MAX_ID_BITS(MAX_ID)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_raw_id       (req_raw_id),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_encoded_code (rsp_encoded_code),
      .rsp_minimal_code (rsp_minimal_code),
      .rsp_canonical_id (rsp_canonical_id),
      .rsp_asymmetric   (rsp_asymmetric)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // Register value to working width: zero acts as 1, above 32 clamps to 32.
   function automatic int unsigned effective_bits(input logic [CfgBits-1:0] cfg);
      int unsigned n;
      n = cfg;
      if (n < 1) n = 1;
      if (n > MAX_ID) n = MAX_ID;
      return n;
   endfunction

   function automatic logic [IdBits-1:0] low_mask(input int unsigned n);
      return (n >= IdBits) ? {IdBits{1'b1}} : ((32'd1 << n) - 32'd1);
   endfunction

   // One-bit right rotation confined to the low w bits.
   function automatic logic [CodeBits-1:0] rotate_in_window(input logic [CodeBits-1:0] v,
                                                            input int unsigned w,
                                                            input logic [CodeBits-1:0] wmask);
      return ((v >> 1) | (CodeBits'(v[0]) << (w - 1))) & wmask;
   endfunction

   function automatic id_result_type canonicalize(input logic [IdBits-1:0] raw,
                                                  input logic [CfgBits-1:0] cfg);
      int unsigned         n;
      int unsigned         w;
      logic [CodeBits-1:0] wmask;
      logic [CodeBits-1:0] rot;
      logic [IdBits-1:0]   id;
      logic                pairs_ok;
      id_result_type       res;
      n     = effective_bits(cfg);
      w     = 2 * n;
      wmask = (w >= CodeBits) ? {CodeBits{1'b1}} : ((64'd1 << w) - 64'd1);
      id    = raw & low_mask(n);
      res   = '0;
      for (int k = 0; k < n; k++) res.encoded[2*k +: 2] = id[k] ? 2'b10 : 2'b01;
      // Minimum search: every rotation, keep the smallest with all pairs valid.
      res.minimal = res.encoded;
      rot         = res.encoded;
      for (int i = 0; i < w; i++) begin
         rot      = rotate_in_window(rot, w, wmask);
         pairs_ok = 1'b1;
         for (int k = 0; k < n; k++) begin
            if (rot[2*k] == rot[2*k+1]) pairs_ok = 1'b0;
         end
         if (rot < res.minimal && pairs_ok) res.minimal = rot;
      end
      // Symmetry check over the nontrivial rotations of the minimum.
      res.asym = 1'b1;
      rot      = res.minimal;
      for (int i = 1; i < w; i++) begin
         rot = rotate_in_window(rot, w, wmask);
         if (rot == res.minimal) res.asym = 1'b0;
      end
      for (int k = 0; k < n; k++) res.canon[k] = res.minimal[2*k+1];
      return res;
   endfunction

   // ------------------------------------------------------------------
   // Monitor and checker: one process, so pop/push order is fixed.
   // Result is checked before the same-edge input push, so a result with
   // nothing outstanding is always caught.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      id_result_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (canon_expect_q.size() == 0) begin
               $error("result transfer with no outstanding item: minimal_code %h",
                      rsp_minimal_code);
               mismatch_count++;
            end else begin
               want = canon_expect_q.pop_front();
               results_checked++;
               if (rsp_encoded_code !== want.encoded) begin
                  $error("encoded_code: expected %h, got %h", want.encoded, rsp_encoded_code);
                  mismatch_count++;
               end
               if (rsp_minimal_code !== want.minimal) begin
                  $error("minimal_code: expected %h, got %h", want.minimal, rsp_minimal_code);
                  mismatch_count++;
               end
               if (rsp_canonical_id !== want.canon) begin
                  $error("canonical_id: expected %h, got %h", want.canon, rsp_canonical_id);
                  mismatch_count++;
               end
               if (rsp_asymmetric !== want.asym) begin
                  $error("asymmetric: expected %b, got %b", want.asym, rsp_asymmetric);
                  mismatch_count++;
               end
            end
         end
         // Prediction uses the register as it stands at the input transfer;
         // it only changes while the unit is drained.
         if (req_valid && req_ready) canon_expect_q.insert(canon_expect_q.size(),
                                                           canonicalize(req_raw_id,
                                                                        id_bits_shadow));
      end
   end

   // ------------------------------------------------------------------
   // Idling
   // ------------------------------------------------------------------

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      else if (r < 90) return $urandom_range(1, 3);
      else if (r < 97) return $urandom_range(4, 20);
      else return $urandom_range(21, 150);
   endfunction

   // Receiver backpressure, independent of rsp_valid so stalls land on any
   // phase of the unit's work.
   always @(posedge clock) begin
      int unsigned gap;
      if (ready_hold > 0) begin
         ready_hold--;
      end else if (!rsp_idle_en) begin
         rsp_ready <= 1'b1;
      end else begin
         gap = pick_gap();
         if (gap == 0) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready  <= 1'b0;
            ready_hold = gap - 1;
         end
      end
   end

   // Watchdog: any run of cycles with no transfer on either side beyond the
   // limit means the unit is hung.
   initial begin : watchdog
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("watchdog: %0d cycles with no transfer", IDLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
   end

   // ------------------------------------------------------------------
   // Shared stimulus helpers
   // ------------------------------------------------------------------

   // Send one raw ID; returns at the edge of its transfer with valid still
   // high, so a back-to-back item never drops valid for a cycle. Whoever
   // pauses next lowers it in this same step.
   task automatic send_id(input logic [IdBits-1:0] id);
      int unsigned gap;
      gap = send_idle_en ? pick_gap() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_raw_id <= id;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // Stop sending and wait for every outstanding result, then settle.
   task automatic drain(input int unsigned settle);
      req_valid <= 1'b0;
      do @(posedge clock); while (canon_expect_q.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   // Reprogram id_bits; only ever called on a drained unit.
   task automatic set_id_bits(input logic [CfgBits-1:0] value);
      drain(SETTLE);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en      <= 1'b0;
      id_bits_shadow = value;
      width_writes++;
   endtask

   // Random raw ID for width n: mostly uniform, some periodic (symmetric
   // codes), some flat or alternating; bits above n always random.
   function automatic logic [IdBits-1:0] pick_id(input int unsigned n);
      int unsigned       r;
      int unsigned       p;
      logic [IdBits-1:0] pat;
      logic [IdBits-1:0] id;
      logic [IdBits-1:0] keep;
      r    = $urandom_range(0, 9);
      keep = low_mask(n);
      id   = $urandom;
      if (r >= 6 && r <= 8) begin
         // Period that divides n, so the code repeats under rotation.
         p = $urandom_range(1, n);
         while (n % p != 0) p--;
         pat = $urandom;
         for (int k = 0; k < IdBits; k++) id[k] = pat[k % p];
      end else if (r == 9) begin
         case ($urandom_range(0, 3))
            0: id = 32'h0000_0000;
            1: id = 32'hFFFF_FFFF;
            2: id = 32'h5555_5555;
            default: id = 32'hAAAA_AAAA;
         endcase
      end
      return (id & keep) | (IdBits'($urandom) & ~keep);
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset width (8) untouched: flat, full, alternating, single bits, and
   // junk above the active bits that must be ignored.
   task automatic test_reset_width();
      send_id(32'h0000_0000);
      send_id(32'h0000_00FF);
      send_id(32'hFFFF_FF00);
      send_id(32'h0000_0055);
      send_id(32'h0000_00AA);
      send_id(32'h0000_000F);
      send_id(32'h0000_0001);
      send_id(32'h0000_0080);
   endtask

   // Full 64-bit window at n = 32.
   task automatic test_full_width();
      set_id_bits(CfgBits'(32));
      send_id(32'h0000_0000);
      send_id(32'hFFFF_FFFF);
      send_id(32'h5555_5555);
      send_id(32'hAAAA_AAAA);
      send_id(32'h8000_0000);
      send_id(32'h0000_0001);
      send_id(32'h0F0F_0F0F);
      send_id(32'h1234_5678);
   endtask

   // Out-of-range register values: zero behaves as 1, above 32 saturates.
   task automatic test_width_clamp();
      set_id_bits(CfgBits'(0));
      send_id(32'h0000_0000);
      send_id(32'h0000_0001);
      send_id(32'hFFFF_FFFF);
      set_id_bits(CfgBits'(63));
      send_id(32'hDEAD_BEEF);
      send_id(32'h3333_3333);
      set_id_bits(CfgBits'(33));
      send_id(32'hFFFF_0000);
   endtask

   // Every ID for the narrow widths, with random upper bits.
   task automatic test_narrow_exhaustive();
      for (int n = 1; n <= 6; n++) begin
         set_id_bits(CfgBits'(n));
         for (int v = 0; v < (1 << n); v++) send_id(IdBits'(v) | (IdBits'($urandom) << n));
      end
   endtask

   // Random IDs over a spread of widths, small ones weighted; idling is
   // switched off in some stretches, and the sender waits out all results
   // once per phase and now and then at random.
   task automatic test_random_widths();
      logic [CfgBits-1:0] widths [18];
      int unsigned        n;
      int unsigned        count;
      widths = '{6'd2, 6'd3, 6'd4, 6'd5, 6'd7, 6'd8, 6'd9, 6'd11, 6'd13, 6'd16,
                 6'd6, 6'd0, 6'd24, 6'd32, 6'd63, 6'd45, 6'd0, 6'd0};
      widths[16] = CfgBits'($urandom_range(0, 63));
      widths[17] = CfgBits'($urandom_range(0, 63));
      foreach (widths[w]) begin
         set_id_bits(widths[w]);
         n     = effective_bits(widths[w]);
         count = (n <= 16) ? 120 : 60;
         for (int i = 0; i < count; i++) begin
            if (i % 30 == 0) begin
               send_idle_en = ($urandom_range(0, 3) != 0);
               rsp_idle_en  = send_idle_en;
            end
            if (i == count / 2 || $urandom_range(0, 49) == 0) drain(0);
            send_id(pick_id(n));
         end
      end
      send_idle_en = 1'b1;
      rsp_idle_en  = 1'b1;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_width();
      test_full_width();
      test_width_clamp();
      test_narrow_exhaustive();
      test_random_widths();

      drain(SETTLE);
      $display("ran %0d IDs through %0d id_bits settings (reset width, 0, 1..32, clamped)",
               items_sent, width_writes + 1);
      $display("checked %0d results, %0d field mismatches", results_checked, mismatch_count);
      if (mismatch_count == 0 && canon_expect_q.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ----- manchester_rotation_canonical_id_unit.f -----
rtl/mrcid_pkg.sv
rtl/manchester_rotation_canonical_id_unit.sv
tb/sv/manchester_rotation_canonical_id_unit_tb.sv
